### src/cbsf_pkg.sv
// ----------------------------------------------------------------------------
// cbsf_pkg
// Shared constants, register codes and helpers for the cube-sphere vertex
// generator.
// ----------------------------------------------------------------------------
package cbsf_pkg;

  localparam int MAX_RES   = 256;
  localparam int FRAC_BITS = 15;

  localparam int RES_W   = 9;
  localparam int FACE_W  = 3;
  localparam int AXIS_W  = 2;
  localparam int CFG_W   = 9;
  localparam int CIDX_W  = 3;
  localparam int GRID_W  = 8;
  localparam int IDX_W   = 19;
  localparam int SLOT_W  = 22;
  localparam int POS_W   = 16;
  localparam int TEX_W   = 16;

  localparam int INDICES_PER_QUAD = 6;

  localparam int SQ_W     = 20;
  localparam int N_W      = 22;
  localparam int DIVN     = 2 * FRAC_BITS + 2;
  localparam int SQN      = FRAC_BITS + 2;
  localparam int NORM_LAT = 1 + DIVN + SQN;
  localparam int TEXN     = FRAC_BITS + 1;

  typedef enum logic [CIDX_W-1:0] {
    REG_RESOLUTION = 3'd0,
    REG_FACE       = 3'd1,
    REG_UP_X       = 3'd2,
    REG_UP_Y       = 3'd3,
    REG_UP_Z       = 3'd4
  } cfg_reg_t;

  function automatic logic signed [1:0] axis_val(input logic [1:0] raw);
    logic signed [1:0] v;
    case (raw)
      2'b00:   v = 2'sd0;
      2'b01:   v = 2'sd1;
      default: v = -2'sd1;
    endcase
    return v;
  endfunction

endpackage

### src/cbsf_point_if.sv
// ----------------------------------------------------------------------------
// cbsf_point_if
// Grid point channel: one face coordinate pair per item.
// ----------------------------------------------------------------------------
interface cbsf_point_if import cbsf_pkg::*;;
  logic              valid;
  logic              ready;
  logic [GRID_W-1:0] grid_x;
  logic [GRID_W-1:0] grid_y;

  modport source (output valid, grid_x, grid_y, input ready);
  modport sink   (input valid, grid_x, grid_y, output ready);
endinterface

### src/cbsf_vertex_if.sv
// ----------------------------------------------------------------------------
// cbsf_vertex_if
// Vertex channel: sphere position, texture coordinates and quad indices.
// ----------------------------------------------------------------------------
interface cbsf_vertex_if import cbsf_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        vertex_index;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [TEX_W-1:0]        tex_u;
  logic [TEX_W-1:0]        tex_v;
  logic                    quad_valid;
  logic [SLOT_W-1:0]       tri_slot;
  logic [IDX_W-1:0]        corner_right;
  logic [IDX_W-1:0]        corner_below;
  logic [IDX_W-1:0]        corner_diag;
  logic                    coord_error;

  modport source (output valid, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                  quad_valid, tri_slot, corner_right, corner_below, corner_diag,
                  coord_error, input ready);
  modport sink   (input valid, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                  quad_valid, tri_slot, corner_right, corner_below, corner_diag,
                  coord_error, output ready);
endinterface

### src/cube_sphere_face_vertex.sv
// ----------------------------------------------------------------------------
// cube_sphere_face_vertex
// Maps a grid point of a cube face to its unit-sphere vertex plus mesh indices.
// ----------------------------------------------------------------------------
// Channels: point (sink) takes grid_x/grid_y; vertex (source) gives the
// vertex index, Q1.15 sphere position, texture coordinates, the quad's
// index-buffer slot and corners, and a coordinate error flag.
// Configuration: wr_en/wr_index/wr_data write resolution, face number and
// the face axis; write only while no item is in flight.
// Throughput: one item per cycle while the vertex channel is not stalled.
// Pipeline: from acceptance to vertex valid, four setup stages, then 50
// normalizer stages (one division bit per stage for 32 stages, one
// root bit per stage for 17 stages, plus entry), then the output register.
// Reset: clears all valid bits and loads resolution 16, face 0, axis (0,1,0).
// Stall: while vertex.ready is low and a vertex is held, the whole pipeline
// freezes and point.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module cube_sphere_face_vertex import cbsf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [CIDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]  wr_data,
  cbsf_point_if.sink        point,
  cbsf_vertex_if.source     vertex
);

  typedef struct packed {
    logic [IDX_W-1:0]  vi;
    logic [SLOT_W-1:0] slot;
    logic [IDX_W-1:0]  cr;
    logic [IDX_W-1:0]  cb;
    logic [IDX_W-1:0]  cd;
    logic              err;
    logic              quad;
    logic              zero;
    logic              negx;
    logic              negy;
    logic              negz;
    logic [9:0]        tx_rem;
    logic [TEXN-1:0]   tx_low;
    logic [TEXN-1:0]   tx_q;
    logic [9:0]        ty_rem;
    logic [TEXN-1:0]   ty_low;
    logic [TEXN-1:0]   ty_q;
  } pay_t;

  logic [RES_W-1:0]  resolution;
  logic [FACE_W-1:0] face_number;
  logic [AXIS_W-1:0] up_x;
  logic [AXIS_W-1:0] up_y;
  logic [AXIS_W-1:0] up_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution  <= RES_W'(16);
      face_number <= '0;
      up_x        <= 2'b00;
      up_y        <= 2'b01;
      up_z        <= 2'b00;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_RESOLUTION: resolution  <= wr_data[RES_W-1:0];
        REG_FACE:       face_number <= wr_data[FACE_W-1:0];
        REG_UP_X:       up_x        <= wr_data[AXIS_W-1:0];
        REG_UP_Y:       up_y        <= wr_data[AXIS_W-1:0];
        REG_UP_Z:       up_z        <= wr_data[AXIS_W-1:0];
        default: ;
      endcase
    end
  end

  // configuration-derived values
  logic [RES_W-1:0]    rc;
  logic [GRID_W-1:0]   d;
  logic [RES_W-1:0]    dv;
  logic signed [1:0]   ux, uy, uz;
  logic signed [2:0]   bx, by, bz;

  always_comb begin
    if (resolution < RES_W'(2)) begin
      rc = RES_W'(2);
    end else if (resolution > RES_W'(MAX_RES)) begin
      rc = RES_W'(MAX_RES);
    end else begin
      rc = resolution;
    end
    d  = GRID_W'(rc - RES_W'(1));
    dv = {d, 1'b0};
    ux = axis_val(up_x);
    uy = axis_val(up_y);
    uz = axis_val(up_z);
    bx = 3'(uy * ux) - 3'(uz * uz);
    by = 3'(uz * uy) - 3'(ux * ux);
    bz = 3'(ux * uz) - 3'(uy * uy);
  end

  logic [16:0]      rr;
  logic [15:0]      dsq;
  logic [IDX_W-1:0] face_off;
  logic [19:0]      face_dd;

  always_ff @(posedge clk) begin
    rr       <= 17'(rc * rc);
    dsq      <= 16'(d * d);
    face_off <= IDX_W'(face_number * rr);
    face_dd  <= 20'(face_number * dsq);
  end

  logic en;
  assign en          = !vertex.valid || vertex.ready;
  assign point.ready = en;

  // stage 1: capture
  logic              v1;
  logic [GRID_W-1:0] x1, y1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= point.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= point.grid_x;
      y1 <= point.grid_y;
    end
  end

  // stage 2: offsets and row products
  logic               v2, err2, quad2;
  logic [GRID_W-1:0]  x2, y2;
  logic signed [10:0] s2, t2;
  logic [16:0]        yr2;
  logic [15:0]        yd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2    <= x1;
      y2    <= y1;
      err2  <= ({1'b0, x1} >= rc) || ({1'b0, y1} >= rc);
      quad2 <= (x1 != d) && (y1 != d);
      s2    <= $signed({2'b00, x1, 1'b0}) - $signed({3'b000, d});
      t2    <= $signed({2'b00, y1, 1'b0}) - $signed({3'b000, d});
      yr2   <= 17'(y1 * rc);
      yd2   <= 16'(y1 * d);
    end
  end

  // stage 3: indices and cube point
  logic               v3, err3, quad3;
  logic [GRID_W-1:0]  x3, y3;
  logic [IDX_W-1:0]   vi3;
  logic [19:0]        tb3;
  logic signed [11:0] px3, py3, pz3;
  logic signed [11:0] dS, sS, tS;

  assign dS = $signed({4'b0000, d});
  assign sS = 12'(s2);
  assign tS = 12'(t2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x3   <= x2;
      y3   <= y2;
      err3 <= err2;
      quad3 <= quad2;
      vi3  <= IDX_W'(face_off + IDX_W'(yr2) + IDX_W'(x2));
      tb3  <= 20'(face_dd + 20'(yd2) + 20'(x2));
      px3  <= 12'(ux) * dS + sS * 12'(uy) + tS * 12'(bx);
      py3  <= 12'(uy) * dS + sS * 12'(uz) + tS * 12'(by);
      pz3  <= 12'(uz) * dS + sS * 12'(ux) + tS * 12'(bz);
    end
  end

  // stage 4: squares, slot and corners
  logic               v4, err4, quad4;
  logic [GRID_W-1:0]  x4, y4;
  logic [IDX_W-1:0]   vi4, cr4, cb4, cd4;
  logic [SLOT_W-1:0]  slot4;
  logic [SQ_W-1:0]    sqx4, sqy4, sqz4;
  logic               negx4, negy4, negz4;
  logic [11:0]        mx, my, mz;

  assign mx = px3[11] ? 12'(-px3) : 12'(px3);
  assign my = py3[11] ? 12'(-py3) : 12'(py3);
  assign mz = pz3[11] ? 12'(-pz3) : 12'(pz3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x4    <= x3;
      y4    <= y3;
      err4  <= err3;
      quad4 <= quad3;
      vi4   <= vi3;
      cr4   <= vi3 + IDX_W'(1);
      cb4   <= vi3 + IDX_W'(rc);
      cd4   <= vi3 + IDX_W'(rc) + IDX_W'(1);
      slot4 <= SLOT_W'(23'(tb3) * 23'(INDICES_PER_QUAD));
      sqx4  <= SQ_W'(mx[9:0] * mx[9:0]);
      sqy4  <= SQ_W'(my[9:0] * my[9:0]);
      sqz4  <= SQ_W'(mz[9:0] * mz[9:0]);
      negx4 <= px3[11];
      negy4 <= py3[11];
      negz4 <= pz3[11];
    end
  end

  // normalizers
  logic [N_W-1:0] n4;
  logic [SQN-1:0] fx, fy, fz;

  assign n4 = N_W'(sqx4) + N_W'(sqy4) + N_W'(sqz4);

  cbsf_unit_norm u_norm_x (.clk(clk), .en(en), .sq(sqx4), .n(n4), .root(fx));
  cbsf_unit_norm u_norm_y (.clk(clk), .en(en), .sq(sqy4), .n(n4), .root(fy));
  cbsf_unit_norm u_norm_z (.clk(clk), .en(en), .sq(sqz4), .n(n4), .root(fz));

  // side payload, texture division in its first stages
  pay_t pay [0:NORM_LAT-1];
  logic vld [0:NORM_LAT-1];
  pay_t pay0;

  always_comb begin
    pay0.vi     = vi4;
    pay0.slot   = slot4;
    pay0.cr     = cr4;
    pay0.cb     = cb4;
    pay0.cd     = cd4;
    pay0.err    = err4;
    pay0.quad   = quad4;
    pay0.zero   = (n4 == '0);
    pay0.negx   = negx4;
    pay0.negy   = negy4;
    pay0.negz   = negz4;
    pay0.tx_rem = 10'(x4);
    pay0.tx_low = TEXN'(d);
    pay0.tx_q   = '0;
    pay0.ty_rem = 10'(y4);
    pay0.ty_low = TEXN'(d);
    pay0.ty_q   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay[0] <= pay0;
    end
  end

  for (genvar i = 1; i < NORM_LAT; i++) begin : g_pay
    pay_t nxt;
    if (i <= TEXN) begin : g_tex
      logic [10:0] trx, try_;
      logic        gex, gey;
      assign trx  = {pay[i-1].tx_rem, pay[i-1].tx_low[TEXN-1]};
      assign try_ = {pay[i-1].ty_rem, pay[i-1].ty_low[TEXN-1]};
      assign gex  = (trx >= {2'b00, dv});
      assign gey  = (try_ >= {2'b00, dv});
      always_comb begin
        nxt        = pay[i-1];
        nxt.tx_rem = gex ? 10'(trx - {2'b00, dv}) : trx[9:0];
        nxt.ty_rem = gey ? 10'(try_ - {2'b00, dv}) : try_[9:0];
        nxt.tx_low = pay[i-1].tx_low << 1;
        nxt.ty_low = pay[i-1].ty_low << 1;
        nxt.tx_q   = {pay[i-1].tx_q[TEXN-2:0], gex};
        nxt.ty_q   = {pay[i-1].ty_q[TEXN-2:0], gey};
      end
    end else begin : g_copy
      assign nxt = pay[i-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld[i-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        pay[i] <= nxt;
      end
    end
  end

  // output register
  function automatic logic [POS_W-1:0] to_pos(input logic [SQN-1:0] f, input logic neg);
    logic [SQN:0]   fp;
    logic [SQN-1:0] k;
    logic [SQN-1:0] m;
    fp = {1'b0, f} + (SQN + 1)'(1);
    k  = fp[SQN:1];
    if (neg) begin
      m = (k > SQN'(2 ** FRAC_BITS)) ? SQN'(2 ** FRAC_BITS) : k;
      return POS_W'(-m);
    end
    m = (k > SQN'(2 ** FRAC_BITS - 1)) ? SQN'(2 ** FRAC_BITS - 1) : k;
    return POS_W'(m);
  endfunction

  pay_t pl;
  logic keep, qk;
  assign pl   = pay[NORM_LAT-1];
  assign keep = !pl.err;
  assign qk   = keep && pl.quad;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex.valid <= 1'b0;
    end else if (en) begin
      vertex.valid <= vld[NORM_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vertex.coord_error  <= pl.err;
      vertex.vertex_index <= keep ? pl.vi : '0;
      vertex.pos_x        <= (keep && !pl.zero) ? to_pos(fx, pl.negx) : '0;
      vertex.pos_y        <= (keep && !pl.zero) ? to_pos(fy, pl.negy) : '0;
      vertex.pos_z        <= (keep && !pl.zero) ? to_pos(fz, pl.negz) : '0;
      vertex.tex_u        <= keep ? TEX_W'(pl.tx_q) : '0;
      vertex.tex_v        <= keep ? TEX_W'(pl.ty_q) : '0;
      vertex.quad_valid   <= qk;
      vertex.tri_slot     <= qk ? pl.slot : '0;
      vertex.corner_right <= qk ? pl.cr : '0;
      vertex.corner_below <= qk ? pl.cb : '0;
      vertex.corner_diag  <= qk ? pl.cd : '0;
    end
  end

endmodule

### src/cbsf_unit_norm.sv
// ----------------------------------------------------------------------------
// cbsf_unit_norm
// Pipelined normalizer for one component: restoring division of sq by n
// one quotient bit per stage, then a digit-by-digit square root one result
// bit per stage. root = floor(sqrt(sq * 2^(2F+2) / n)).
// ----------------------------------------------------------------------------
module cbsf_unit_norm import cbsf_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [SQ_W-1:0] sq,
  input  logic [N_W-1:0]  n,
  output logic [SQN-1:0]  root
);

  localparam int QW = DIVN + 1;

  logic [N_W-1:0] drem [0:DIVN];
  logic [N_W-1:0] dn   [0:DIVN-1];
  logic [QW-1:0]  dq   [0:DIVN];
  logic [QW-1:0]  sv   [0:SQN-1];
  logic [QW-1:0]  sr   [0:SQN];

  logic eq0;
  assign eq0 = (N_W'(sq) == n);

  always_ff @(posedge clk) begin
    if (en) begin
      drem[0] <= eq0 ? '0 : N_W'(sq);
      dq[0]   <= QW'(eq0);
      dn[0]   <= n;
    end
  end

  for (genvar i = 1; i <= DIVN; i++) begin : g_div
    logic [N_W:0] trial;
    logic         ge;
    assign trial = {drem[i-1], 1'b0};
    assign ge    = (trial >= {1'b0, dn[i-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        drem[i] <= ge ? N_W'(trial - {1'b0, dn[i-1]}) : trial[N_W-1:0];
        dq[i]   <= {dq[i-1][QW-2:0], ge};
      end
    end
    if (i < DIVN) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          dn[i] <= dn[i-1];
        end
      end
    end
  end

  assign sv[0] = dq[DIVN];
  assign sr[0] = '0;

  for (genvar j = 0; j < SQN; j++) begin : g_sqrt
    localparam logic [QW:0] BIT = (QW + 1)'(1) << (2 * (SQN - 1 - j));
    logic [QW:0] sum;
    logic        ge;
    assign sum = {1'b0, sr[j]} + BIT;
    assign ge  = ({1'b0, sv[j]} >= sum);
    always_ff @(posedge clk) begin
      if (en) begin
        sr[j+1] <= ge ? QW'(({1'b0, sr[j]} >> 1) + BIT) : (sr[j] >> 1);
      end
    end
    if (j < SQN - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          sv[j+1] <= ge ? QW'({1'b0, sv[j]} - sum) : sv[j];
        end
      end
    end
  end

  assign root = sr[SQN][SQN-1:0];

endmodule
